/* hw/rtl/ffe_pkg.sv */
// Shared types, constants and helpers of the framebuffer fill engine.
`default_nettype none

package ffe_pkg;

   // Screen limits used for clipping
   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;

   // Field widths
   localparam int COORD_W  = 13;          // column / row counters
   localparam int STRIDE_W = 14;
   localparam int OFFSET_W = 26;
   localparam int COLOR_W  = 24;
   localparam int CHAN_W   = 8;

   // Gradient division: |diff| (8 bits) times row (13 bits), over a 13-bit denominator
   localparam int PROD_W    = CHAN_W + COORD_W;
   localparam int DIV_STEPS = PROD_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   typedef enum logic [2:0] {
      OP_PUT   = 3'd0,
      OP_FILL  = 3'd1,
      OP_CLEAR = 3'd2,
      OP_GRAD  = 3'd3,
      OP_TICK  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      KIND_PUT   = 2'd0,
      KIND_FILL  = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_GRAD  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_STRIDE = 2'd2,
      CSR_SWAP   = 2'd3
   } csr_type;

   // Divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // 0xRRGGBB to memory byte order
   function automatic logic [COLOR_W-1:0] native_of(input logic [COLOR_W-1:0] rgb,
                                                    input logic swap);
      if (swap) begin
         return {rgb[7:0], rgb[15:8], rgb[23:16]};
      end
      return rgb;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/ffe_divider.sv */
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module ffe_divider
   import ffe_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [PROD_W-1:0]   dividend,
   input  wire logic [COORD_W-1:0]  divisor,
   output div_status_type           status,
   output logic [PROD_W-1:0]        quotient
);

   logic [COORD_W-1:0]   rem_ff;
   logic [PROD_W-1:0]    quo_ff;
   logic [COORD_W-1:0]   den_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   logic [COORD_W:0]     shifted;
   logic [COORD_W+1:0]   trial;

   // Shift in the next dividend bit and try a subtract
   assign shifted = {rem_ff, quo_ff[PROD_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= '0;
            quo_ff  <= dividend;
            den_ff  <= divisor;
            cnt_ff  <= DIV_CNT_W'(DIV_STEPS);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (!trial[COORD_W+1]) begin
               rem_ff <= trial[COORD_W-1:0];
               quo_ff <= {quo_ff[PROD_W-2:0], 1'b1};
            end else begin
               rem_ff <= shifted[COORD_W-1:0];
               quo_ff <= {quo_ff[PROD_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status   = {busy_ff, done_ff};
   assign quotient = quo_ff;

endmodule

`default_nettype wire

/* hw/rtl/framebuffer_fill_engine_unit.sv */
// Framebuffer fill engine: command decode, clipping, pixel walk and gradient sequencer.
// A tick on a solid-colour job passes through the offset step, which registers its pixel write.
// A gradient tick runs red, green and blue in turn through one shared 21-step divider.
// A command loads its job registers and leaves the sequencer idle.
// The request side stalls while a tick is being worked on or its result waits.
// Synchronous active-high reset: idle, no job, screen 640x480, stride 640, no swap.
`default_nettype none

module framebuffer_fill_engine_unit
   import ffe_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // command / tick channel
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [2:0]           req_op,
   input  wire logic [11:0]          req_pos_x,
   input  wire logic [11:0]          req_pos_y,
   input  wire logic [11:0]          req_rect_width,
   input  wire logic [11:0]          req_rect_height,
   input  wire logic [COLOR_W-1:0]   req_color,
   input  wire logic [COLOR_W-1:0]   req_second_color,
   // pixel write channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [OFFSET_W-1:0]       rsp_pixel_offset,
   output logic [COLOR_W-1:0]        rsp_pixel_value,
   output logic                      rsp_last,
   // register writes
   input  wire logic                 csr_write,
   input  wire logic [1:0]           csr_index,
   input  wire logic [STRIDE_W-1:0]  csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OFFSET,
      ST_PREP,
      ST_START,
      ST_WAIT
   } state_type;

   // registers and next values
   state_type          state_ff,  state_in;
   logic [COORD_W-1:0] scr_w_ff, scr_w_in, scr_h_ff, scr_h_in;
   logic [STRIDE_W-1:0] stride_ff, stride_in;
   logic               swap_ff, swap_in;
   logic               active_ff, active_in;
   kind_type           kind_ff, kind_in;
   logic [COORD_W-1:0] cur_col_ff, cur_col_in, cur_row_ff, cur_row_in;
   logic [COORD_W-1:0] start_col_ff, start_col_in, end_col_ff, end_col_in;
   logic [COORD_W-1:0] end_row_ff, end_row_in;
   logic [COLOR_W-1:0] fill_ff, fill_in, top_ff, top_in, bot_ff, bot_in;
   logic [COORD_W-1:0] work_col_ff, work_col_in, work_row_ff, work_row_in;
   logic               work_last_ff, work_last_in, work_grad_ff, work_grad_in;
   logic [OFFSET_W-1:0] off_ff, off_in;
   logic [1:0]         chan_ff, chan_in;
   logic [COLOR_W-1:0] grad_ff, grad_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic               neg_ff, neg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OFFSET_W-1:0] rsp_off_ff, rsp_off_in;
   logic [COLOR_W-1:0] rsp_val_ff, rsp_val_in;
   logic               rsp_last_ff, rsp_last_in;

   // combinational helpers
   logic               req_fire;
   logic [COORD_W-1:0] clip_w, clip_h, denom;
   logic [COORD_W-1:0] x0, y0, x1, y1, xe, ye;
   logic               new_job;
   kind_type           new_kind;
   logic [COORD_W:0]   col_next, row_next;
   logic               tick_last;
   logic [COORD_W+STRIDE_W-1:0] row_mul;
   logic [CHAN_W-1:0]  ch_top, ch_bot, ch_mag, ch_q, ch_val;
   logic [CHAN_W:0]    ch_diff;
   logic [COLOR_W-1:0] grad_rgb;
   logic               div_start;
   div_status_type     div_stat;
   logic [PROD_W-1:0]  div_quo;

   assign req_fire  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);

   // clip bounds and gradient denominator
   assign clip_w = (scr_w_ff > COORD_W'(MAX_WIDTH))  ? COORD_W'(MAX_WIDTH)  : scr_w_ff;
   assign clip_h = (scr_h_ff > COORD_W'(MAX_HEIGHT)) ? COORD_W'(MAX_HEIGHT) : scr_h_ff;
   assign denom  = (clip_h > COORD_W'(1)) ? clip_h - 1'b1 : COORD_W'(1);

   // rectangle end before clipping
   assign xe = {1'b0, req_pos_x} + {1'b0, req_rect_width};
   assign ye = {1'b0, req_pos_y} + {1'b0, req_rect_height};

   // walk position after this pixel
   assign col_next  = {1'b0, cur_col_ff} + 1'b1;
   assign row_next  = {1'b0, cur_row_ff} + 1'b1;
   assign tick_last = (col_next >= {1'b0, end_col_ff}) && (row_next >= {1'b0, end_row_ff});

   assign row_mul = work_row_ff * stride_ff;

   // gradient channel selection, red first
   always_comb begin
      unique case (chan_ff)
         2'd0: begin
            ch_top = top_ff[23:16];
            ch_bot = bot_ff[23:16];
         end
         2'd1: begin
            ch_top = top_ff[15:8];
            ch_bot = bot_ff[15:8];
         end
         default: begin
            ch_top = top_ff[7:0];
            ch_bot = bot_ff[7:0];
         end
      endcase
   end

   assign ch_diff = {1'b0, ch_bot} - {1'b0, ch_top};
   assign ch_mag  = ch_diff[CHAN_W] ? CHAN_W'(~ch_diff + 1'b1) : ch_diff[CHAN_W-1:0];
   // truncating unsigned quotient of the magnitude, kept to 8 bits; the sign is applied after
   assign ch_q    = div_quo[CHAN_W-1:0];
   assign ch_val  = neg_ff ? ch_top - ch_q : ch_top + ch_q;
   assign grad_rgb = {grad_ff[23:8], ch_val};

   assign div_start = (state_ff == ST_START);

   ffe_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (denom),
      .status   (div_stat),
      .quotient (div_quo)
   );

   // command decode: bounds of a new job
   always_comb begin
      new_job  = 1'b0;
      new_kind = KIND_PUT;
      x0 = '0;
      y0 = '0;
      x1 = '0;
      y1 = '0;
      if (req_fire) begin
         unique case (req_op)
            OP_PUT: begin
               new_job  = 1'b1;
               new_kind = KIND_PUT;
               if (({1'b0, req_pos_x} < clip_w) && ({1'b0, req_pos_y} < clip_h)) begin
                  x0 = {1'b0, req_pos_x};
                  y0 = {1'b0, req_pos_y};
                  x1 = {1'b0, req_pos_x} + 1'b1;
                  y1 = {1'b0, req_pos_y} + 1'b1;
               end
            end
            OP_FILL: begin
               new_job  = 1'b1;
               new_kind = KIND_FILL;
               x0 = {1'b0, req_pos_x};
               y0 = {1'b0, req_pos_y};
               x1 = (xe > clip_w) ? clip_w : xe;
               y1 = (ye > clip_h) ? clip_h : ye;
            end
            OP_CLEAR: begin
               new_job  = 1'b1;
               new_kind = KIND_CLEAR;
               x1 = clip_w;
               y1 = clip_h;
            end
            OP_GRAD: begin
               new_job  = 1'b1;
               new_kind = KIND_GRAD;
               x1 = clip_w;
               y1 = clip_h;
            end
            default: begin
               new_job = 1'b0;
            end
         endcase
      end
   end

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      scr_w_in     = scr_w_ff;
      scr_h_in     = scr_h_ff;
      stride_in    = stride_ff;
      swap_in      = swap_ff;
      active_in    = active_ff;
      kind_in      = kind_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      start_col_in = start_col_ff;
      end_col_in   = end_col_ff;
      end_row_in   = end_row_ff;
      fill_in      = fill_ff;
      top_in       = top_ff;
      bot_in       = bot_ff;
      work_col_in  = work_col_ff;
      work_row_in  = work_row_ff;
      work_last_in = work_last_ff;
      work_grad_in = work_grad_ff;
      off_in       = off_ff;
      chan_in      = chan_ff;
      grad_in      = grad_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_off_in   = rsp_off_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_last_in  = rsp_last_ff;

      // register writes
      if (csr_write) begin
         unique case (csr_index)
            CSR_WIDTH:  scr_w_in  = csr_wdata[COORD_W-1:0];
            CSR_HEIGHT: scr_h_in  = csr_wdata[COORD_W-1:0];
            CSR_STRIDE: stride_in = csr_wdata;
            default:    swap_in   = csr_wdata[0];
         endcase
      end

      // output register drains
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // job start
      if (new_job) begin
         kind_in      = new_kind;
         active_in    = (x0 < x1) && (y0 < y1);
         start_col_in = x0;
         cur_col_in   = x0;
         cur_row_in   = y0;
         end_col_in   = x1;
         end_row_in   = y1;
         if (new_kind == KIND_GRAD) begin
            top_in = req_color;
            bot_in = req_second_color;
         end else begin
            fill_in = native_of(req_color, swap_ff);
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            // tick on a running job: latch the pixel and step the walk
            if (req_fire && (req_op == OP_TICK) && active_ff) begin
               work_col_in  = cur_col_ff;
               work_row_in  = cur_row_ff;
               work_last_in = tick_last;
               work_grad_in = (kind_ff == KIND_GRAD);
               if (tick_last) begin
                  active_in = 1'b0;
               end else if (col_next >= {1'b0, end_col_ff}) begin
                  cur_col_in = start_col_ff;
                  cur_row_in = row_next[COORD_W-1:0];
               end else begin
                  cur_col_in = col_next[COORD_W-1:0];
               end
               state_in = ST_OFFSET;
            end
         end
         ST_OFFSET: begin
            off_in = row_mul[OFFSET_W-1:0] + {{(OFFSET_W-COORD_W){1'b0}}, work_col_ff};
            if (work_grad_ff) begin
               chan_in  = 2'd0;
               state_in = ST_PREP;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_off_in   = row_mul[OFFSET_W-1:0]
                              + {{(OFFSET_W-COORD_W){1'b0}}, work_col_ff};
               rsp_val_in   = fill_ff;
               rsp_last_in  = work_last_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_PREP: begin
            prod_in  = ch_mag * work_row_ff;
            neg_in   = ch_diff[CHAN_W];
            state_in = ST_START;
         end
         ST_START: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_stat.done) begin
               unique case (chan_ff)
                  2'd0:    grad_in[23:16] = ch_val;
                  2'd1:    grad_in[15:8]  = ch_val;
                  default: grad_in[7:0]   = ch_val;
               endcase
               if (chan_ff == 2'd2) begin
                  rsp_valid_in = 1'b1;
                  rsp_off_in   = off_ff;
                  rsp_val_in   = native_of(grad_rgb, swap_ff);
                  rsp_last_in  = work_last_ff;
                  state_in     = ST_IDLE;
               end else begin
                  chan_in  = chan_ff + 1'b1;
                  state_in = ST_PREP;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scr_w_ff     <= COORD_W'(640);
         scr_h_ff     <= COORD_W'(480);
         stride_ff    <= STRIDE_W'(640);
         swap_ff      <= 1'b0;
         active_ff    <= 1'b0;
         kind_ff      <= KIND_PUT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scr_w_ff     <= scr_w_in;
         scr_h_ff     <= scr_h_in;
         stride_ff    <= stride_in;
         swap_ff      <= swap_in;
         active_ff    <= active_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_col_ff   <= cur_col_in;
      cur_row_ff   <= cur_row_in;
      start_col_ff <= start_col_in;
      end_col_ff   <= end_col_in;
      end_row_ff   <= end_row_in;
      fill_ff      <= fill_in;
      top_ff       <= top_in;
      bot_ff       <= bot_in;
      work_col_ff  <= work_col_in;
      work_row_ff  <= work_row_in;
      work_last_ff <= work_last_in;
      work_grad_ff <= work_grad_in;
      off_ff       <= off_in;
      chan_ff      <= chan_in;
      grad_ff      <= grad_in;
      prod_ff      <= prod_in;
      neg_ff       <= neg_in;
      rsp_off_ff   <= rsp_off_in;
      rsp_val_ff   <= rsp_val_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_offset = rsp_off_ff;
   assign rsp_pixel_value  = rsp_val_ff;
   assign rsp_last         = rsp_last_ff;

   // a new result only comes out of the offset or divider-wait step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_OFFSET || $past(state_ff) == ST_WAIT))
      else $error("result raised outside of a compute step");

   // the divider is never restarted while it is still iterating
   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   // divider completion is only seen while the sequencer waits for it
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_WAIT))
      else $error("divider finished outside the wait step");

   // a command transfer never starts a compute sequence
   a_cmd_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_op != OP_TICK)) |=> (state_ff == ST_IDLE))
      else $error("command transfer left the idle state");

endmodule

`default_nettype wire
